// File: rtl/core/grr_pkg.sv
// shared constants and item types for the group reverse reorder block
// no dependencies
package grr_pkg;

    localparam int MAX_GROUP = 64;
    localparam int ADDR_W    = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int GSZ_W     = 7;
    localparam int WORD_W    = 32;
    localparam int CMP_W     = (CNT_W > GSZ_W) ? CNT_W : GSZ_W;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_in;
        logic                     list_end_in;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic                     run_last;
        logic                     list_end_out;
    } out_item_t;

endpackage

// File: rtl/core/grr_buffer.sv
// group word buffer: one write port, one registered read port
// depends on grr_pkg
module grr_buffer (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [grr_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [grr_pkg::WORD_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [grr_pkg::ADDR_W-1:0]  rd_addr,
    output logic [grr_pkg::WORD_W-1:0]  rd_data
);

    logic [grr_pkg::WORD_W-1:0] mem [grr_pkg::MAX_GROUP];
    logic [grr_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/group_reverse_reorder_top.sv
// Reverses a word list in groups of group_size words; leftovers keep their order.
// An item that yields no result leaves the block idle, so the next item can be taken in the next cycle.
// An item that flushes n words holds off input until all n words are out: each word
// is read from the buffer in S_READ, then shown in S_SHOW until out_ready takes it.
// Reset clears the fill count and sets group_size to 1; buffer contents stay undefined.
// Depends on grr_pkg and grr_buffer.
module group_reverse_reorder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  grr_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output grr_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [grr_pkg::GSZ_W-1:0] cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SHOW = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [grr_pkg::GSZ_W-1:0]   gsize_reg;
    logic [grr_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [grr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [grr_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic                        rev_reg, rev_next;
    logic                        end_reg, end_next;

    logic                        in_fire;
    logic [grr_pkg::ADDR_W-1:0]  wr_idx;
    logic [grr_pkg::CNT_W-1:0]   n_cnt;
    logic [grr_pkg::CMP_W-1:0]   g_eff;
    logic [grr_pkg::CMP_W-1:0]   n_cmp;
    logic                        group_full;
    logic                        rd_en;
    logic [grr_pkg::WORD_W-1:0]  rd_data;
    logic                        last_word;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    // group size zero acts as one, oversize saturates
    always_comb
    begin
        if (gsize_reg == '0)
        begin
            g_eff = grr_pkg::CMP_W'(1);
        end
        else if (grr_pkg::CMP_W'(gsize_reg) > grr_pkg::CMP_W'(grr_pkg::MAX_GROUP))
        begin
            g_eff = grr_pkg::CMP_W'(grr_pkg::MAX_GROUP);
        end
        else
        begin
            g_eff = grr_pkg::CMP_W'(gsize_reg);
        end
    end

    always_comb
    begin
        if (fill_reg >= grr_pkg::CNT_W'(grr_pkg::MAX_GROUP))
        begin
            wr_idx = '0;
        end
        else
        begin
            wr_idx = fill_reg[grr_pkg::ADDR_W-1:0];
        end
    end

    assign n_cnt      = grr_pkg::CNT_W'(wr_idx) + grr_pkg::CNT_W'(1);
    assign n_cmp      = grr_pkg::CMP_W'(n_cnt);
    assign group_full = (n_cmp >= g_eff);
    assign last_word  = (cnt_reg == grr_pkg::CNT_W'(1));
    assign rd_en      = (state_reg == S_READ);

    grr_buffer u_buffer (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (wr_idx),
        .wr_data (in_item.word_in),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        rev_next   = rev_reg;
        end_next   = end_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (group_full || in_item.list_end_in)
                    begin
                        state_next = S_READ;
                        fill_next  = '0;
                        cnt_next   = n_cnt;
                        rev_next   = group_full;
                        end_next   = in_item.list_end_in;
                        addr_next  = group_full ? wr_idx : '0;
                    end
                    else
                    begin
                        fill_next = n_cnt;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_ready)
                begin
                    cnt_next = cnt_reg - grr_pkg::CNT_W'(1);
                    if (last_word)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                        // reverse walks down from the newest word
                        addr_next  = rev_reg ? addr_reg - grr_pkg::ADDR_W'(1)
                                             : addr_reg + grr_pkg::ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            gsize_reg <= grr_pkg::GSZ_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                gsize_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        rev_reg  <= rev_next;
        end_reg  <= end_next;
    end

    assign out_valid             = (state_reg == S_SHOW);
    assign out_item.word_out     = rd_data;
    assign out_item.run_last     = last_word;
    assign out_item.list_end_out = last_word && end_reg;

endmodule

// File: dv/grr_reorder_checker.sv
`timescale 1ns / 1ps
// checker for group_reverse_reorder_top: predicts the reordered word stream from the
// accepted input and config items and compares every result item; uses grr_pkg types
module grr_reorder_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  grr_pkg::in_item_t         in_item,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  grr_pkg::out_item_t        out_item,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [grr_pkg::GSZ_W-1:0] cfg_data,
    output int                        fails,
    output int                        pending
);

    logic [grr_pkg::WORD_W-1:0] held_words [grr_pkg::MAX_GROUP];
    int                         words_held = 0;
    logic [grr_pkg::GSZ_W-1:0]  group_size = grr_pkg::GSZ_W'(1);
    grr_pkg::out_item_t         due_words [$];

    // zero acts as one, anything past the buffer depth saturates
    function automatic int group_len();
        if (group_size == '0)
        begin
            return 1;
        end
        if (group_size > grr_pkg::GSZ_W'(grr_pkg::MAX_GROUP))
        begin
            return grr_pkg::MAX_GROUP;
        end
        return int'(group_size);
    endfunction

    task automatic queue_reorder(input grr_pkg::in_item_t it);
        grr_pkg::out_item_t r;
        int                 g;
        int                 n;
        g = group_len();
        if (words_held >= grr_pkg::MAX_GROUP)
        begin
            words_held = 0;
        end
        held_words[words_held] = it.word_in;
        words_held++;
        n = words_held;
        if (n >= g || it.list_end_in)
        begin
            for (int k = 0; k < n; k++)
            begin
                // a full group leaves newest first, a short tail keeps its order
                r.word_out     = (n >= g) ? held_words[n - 1 - k] : held_words[k];
                r.run_last     = (k == n - 1);
                r.list_end_out = (k == n - 1) && it.list_end_in;
                due_words.push_back(r);
            end
            words_held = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [grr_pkg::WORD_W-1:0] want,
                               input logic [grr_pkg::WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grr_pkg::out_item_t want;
        if (!rst_n)
        begin
            words_held = 0;
            group_size = grr_pkg::GSZ_W'(1);
            due_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                group_size = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                queue_reorder(in_item);
            end
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("unexpected result item: word_out %0h", out_item.word_out);
                    fails++;
                end
                else
                begin
                    want = due_words.pop_front();
                    check_field("word_out", want.word_out, out_item.word_out);
                    check_field("run_last", grr_pkg::WORD_W'(want.run_last),
                                grr_pkg::WORD_W'(out_item.run_last));
                    check_field("list_end_out", grr_pkg::WORD_W'(want.list_end_out),
                                grr_pkg::WORD_W'(out_item.list_end_out));
                end
            end
        end
        pending = due_words.size();
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// top of the group reverse reorder testbench: clock, reset, stimulus and verdict
// depends on grr_pkg, group_reverse_reorder_top and grr_reorder_checker
module tb_top;

    localparam int RANDOM_ITEMS = 200;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_CYCLES  = 400;
    localparam int CFG_SETTLE   = 8;
    localparam int DRAIN_CYCLES = 200;
    localparam int QUIET_LIMIT  = 4000;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    grr_pkg::in_item_t         in_item   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    grr_pkg::out_item_t        out_item;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [grr_pkg::GSZ_W-1:0] cfg_data  = '0;

    logic steady       = 1'b0;
    int   hold_reqs    = 0;
    int   holds_done   = 0;
    int   quiet_cycles = 0;
    int   fails;
    int   pending;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    group_reverse_reorder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    grr_reorder_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("group_reverse_reorder_top regression: fail");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request to back up the block
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_done)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [grr_pkg::WORD_W-1:0] w, input logic last_one);
        grr_pkg::in_item_t it;
        it.word_in     = w;
        it.list_end_in = last_one;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_group_size(input logic [grr_pkg::GSZ_W-1:0] gs);
        wait_for_results();
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_data  <= gs;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                        phase;
        int                        sent;
        int                        len;
        logic [grr_pkg::GSZ_W-1:0] gs;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // group size from reset: straight through
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        // full group reversed, then a short tail in order
        set_group_size(7'd3);
        send_word(32'd1, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd3, 1'b0);
        send_word(32'd4, 1'b0);
        send_word(32'd5, 1'b1);
        // end mark landing on a full group
        send_word(32'd6, 1'b0);
        send_word(32'd7, 1'b0);
        send_word(32'hffff_ffff, 1'b1);
        // zero acts as one
        set_group_size(7'd0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        // oversize saturates; list ends early
        set_group_size(7'd127);
        send_word(32'h0000_ffff, 1'b0);
        send_word(32'hffff_0000, 1'b0);
        send_word(32'h5555_5555, 1'b1);
        // size lowered while words are buffered
        set_group_size(7'd5);
        send_word(32'd9, 1'b0);
        send_word(32'd10, 1'b0);
        send_word(32'd11, 1'b0);
        set_group_size(7'd2);
        send_word(32'haaaa_aaaa, 1'b0);
        set_group_size(7'd64);
        send_word(32'h8000_0001, 1'b1);

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                1: gs = 7'd127;
                2: gs = 7'd2;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gs = grr_pkg::GSZ_W'($urandom_range(1, 6));
                        6, 7:             gs = grr_pkg::GSZ_W'($urandom_range(7, 20));
                        default:          gs = grr_pkg::GSZ_W'($urandom_range(0, 127));
                    endcase
                end
            endcase
            set_group_size(gs);
            steady <= (phase == 3);
            if (phase == 2)
            begin
                hold_reqs <= hold_reqs + 1;
            end
            len = (phase == 1) ? 66 : (phase == 2) ? 40 : $urandom_range(8, 30);
            for (int i = 0; i < len; i++)
            begin
                // phase 1: one full largest group, then a short tail closing the list; else random ends
                send_word($urandom,
                          (phase == 1) ? (i == len - 1) : ($urandom_range(0, 15) == 0));
                sent++;
            end
            phase++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fails == 0)
        begin
            $display("group_reverse_reorder_top regression: pass");
        end
        else
        begin
            $display("group_reverse_reorder_top regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/grr_pkg.sv
rtl/core/grr_buffer.sv
rtl/core/group_reverse_reorder_top.sv
dv/grr_reorder_checker.sv
dv/tb_top.sv
